>>> rtl/linear_resampler_with_volume_fade_unit_assert.svh
// Assertion macros shared by the resampler RTL.
`ifndef LINEAR_RESAMPLER_WITH_VOLUME_FADE_UNIT_ASSERT_SVH
`define LINEAR_RESAMPLER_WITH_VOLUME_FADE_UNIT_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define LRSVF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A trigger that implies a condition in the next cycle.
`define LRSVF_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> rtl/lrsvf_pkg.sv
// Package with shared types, constants and tables of the resampler.
`timescale 1ns / 1ps
`default_nettype none
package lrsvf_pkg;
	localparam int FracBitsDefault = 16;
	localparam int FadeBitsDefault = 24;
	localparam int MaxOutputsDefault = 64;

	localparam int StepWidth = 19;
	localparam int VolWidth = 17;
	localparam int PctEntries = 128;

	typedef logic [VolWidth-1:0] vol_t;
	typedef vol_t pct_table_t [0:PctEntries-1];

	localparam vol_t VolOne = vol_t'(65536);
	localparam logic [StepWidth-1:0] StepReset = StepWidth'(65536);

	typedef enum logic [1:0] {
		REQ_FRAME  = 2'd0,
		REQ_VOLUME = 2'd1,
		REQ_STOP   = 2'd2
	} req_t;

	localparam logic REG_STEP_RATIO = 1'b0;
	localparam logic REG_MONO_SOURCE = 1'b1;

	function automatic pct_table_t build_pct_table();
		pct_table_t tbl;
		int p;
		for (int i = 0; i < PctEntries; i++) begin
			p = (i > 100) ? 100 : i;
			tbl[i] = vol_t'((p * 65536 + 50) / 100);
		end
		return tbl;
	endfunction

	localparam pct_table_t PctTable = build_pct_table();
endpackage
`default_nettype wire

>>> rtl/lrsvf_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lrsvf_div #(
	parameter int DW = 24,
	parameter int QW = 17,
	parameter int NW = DW + QW
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               busy,
	output logic [QW-1:0]      quotient
);
	localparam int CW = $clog2(QW + 1);

	logic [DW-1:0] rem_q;
	logic [QW-1:0] sh_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;
	logic          ge;
	logic [DW:0]   diff;

	always_comb begin
		trial = {rem_q, sh_q[QW-1]};
		ge = trial >= {1'b0, divisor};
		diff = trial - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[NW-1:QW];
			sh_q <= dividend[QW-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			sh_q <= {sh_q[QW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quotient = sh_q;
endmodule
`default_nettype wire

>>> rtl/linear_resampler_with_volume_fade_unit.sv
// Top level: linear resampler with volume slide, one shared multiplier and a sequencer.
// Each output frame runs a loop check, two channel passes and an emit.
// A running volume slide adds a multiply, a divider start and a divide per output.
// A source frame runs its outputs, up to MAX_OUTPUTS of them, then a finish; a stalled
// result holds the emit and finish steps. Volume, stop and first priming frames stay idle.
// Reset is asynchronous and active low; it restores the control and channel state.
`timescale 1ns / 1ps
`default_nettype none
`include "linear_resampler_with_volume_fade_unit_assert.svh"
module linear_resampler_with_volume_fade_unit #(
	parameter int FRAC_BITS = lrsvf_pkg::FracBitsDefault,
	parameter int FADE_BITS = lrsvf_pkg::FadeBitsDefault,
	parameter int MAX_OUTPUTS = lrsvf_pkg::MaxOutputsDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// left_sample, right_sample, from_percent, to_percent, fade_length, zero pad
	input  wire logic [71:0] s_axis_tdata,
	// req_type
	input  wire logic [1:0]  s_axis_tuser,
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// left_out, right_out
	output logic [31:0]      m_axis_tdata,
	output logic             m_axis_tlast
);
	localparam int F = FRAC_BITS;
	localparam int FB = FADE_BITS;
	localparam int SW = (F > lrsvf_pkg::StepWidth) ? F : lrsvf_pkg::StepWidth;
	localparam int PHW = SW + 1;
	localparam int MA = ((FB > F + 2) ? FB : F + 2) + 1;
	localparam int MB = 18;
	localparam int PRW = MA + MB;
	localparam int IW = F + 18;
	localparam int HPW = F + 20;
	localparam int SUMW = F + 36;
	localparam int SH = F + 16;
	localparam int RW = SUMW - SH;
	localparam int NW = FB + 17;
	localparam int CW = $clog2(MAX_OUTPUTS + 1);
	localparam int MinStep = ((1 << F) + MAX_OUTPUTS - 1) / MAX_OUTPUTS;
	localparam logic [PHW-1:0] PhaseOne = PHW'(1) << F;
	localparam logic [SUMW-1:0] RoundBias = (SUMW'(1) << SH) - SUMW'(1);
	localparam logic [FB-1:0] FadeMax = {FB{1'b1}};

	typedef enum logic [3:0] {
		S_IDLE, S_LOOP, S_FADE_MUL, S_FADE_START, S_FADE_DIV, S_FADE_UPD,
		S_CH_MUL, S_CH_INT, S_CH_LO, S_CH_HI, S_CH_SUM, S_CH_CLAMP,
		S_EMIT, S_FINISH
	} state_t;

	state_t state_q;

	logic [lrsvf_pkg::StepWidth-1:0] step_q;
	logic mono_q;

	logic signed [15:0] cur_l_q, cur_r_q, nxt_l_q, nxt_r_q;
	logic [PHW-1:0] phase_q;
	logic [1:0] prime_q;
	logic finished_q;
	lrsvf_pkg::vol_t vol_q, target_q, start_q;
	logic [FB-1:0] rem_q, span_q;
	logic stop_fade_q;
	logic last_q;
	logic [CW-1:0] cnt_q;
	logic ch_q;

	logic signed [PRW-1:0] prod_q;
	logic signed [IW-1:0] interp_q;
	logic [32:0] plo_q;
	logic signed [SUMW-1:0] psum_q;
	logic signed [15:0] res_l_q, res_r_q;
	logic signed [15:0] pend_l_q, pend_r_q;
	logic pend_valid_q;

	logic m_valid_q;
	logic m_last_q;
	logic signed [15:0] m_l_q, m_r_q;

	logic signed [MA-1:0] mul_a;
	logic signed [MB-1:0] mul_b;

	logic cfg_wr;
	logic in_acc;
	logic out_free;
	logic m_load;
	logic [SW-1:0] step_eff;
	logic diff_neg;
	lrsvf_pkg::vol_t abs_diff;
	logic [FB-1:0] done_cnt;
	logic div_start;
	logic div_busy;
	logic [16:0] div_q;
	logic signed [15:0] cur_sel, nxt_sel;
	logic signed [16:0] frame_diff;
	logic signed [IW-1:0] cur_shift;
	logic signed [SUMW-1:0] hi_ext;
	logic signed [SUMW-1:0] biased;
	logic signed [RW-1:0] quot;
	logic signed [15:0] clamped;

	logic signed [15:0] in_l, in_r;
	logic signed [7:0] in_from;
	logic [6:0] in_to;
	logic [23:0] in_len;
	logic [FB-1:0] len_sat;
	lrsvf_pkg::vol_t from_vol, to_vol;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign in_acc = s_axis_tvalid & s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign out_free = !m_valid_q || m_axis_tready;
	assign m_load = (state_q == S_EMIT || state_q == S_FINISH) && pend_valid_q && out_free;

	always_comb begin
		unique case (paddr[2])
			lrsvf_pkg::REG_STEP_RATIO:  prdata = 32'(step_q);
			lrsvf_pkg::REG_MONO_SOURCE: prdata = 32'(mono_q);
			default:                    prdata = '0;
		endcase
	end

	always_comb begin
		in_l = s_axis_tdata[15:0];
		in_r = mono_q ? s_axis_tdata[15:0] : s_axis_tdata[31:16];
		in_from = s_axis_tdata[39:32];
		in_to = s_axis_tdata[46:40];
		in_len = s_axis_tdata[70:47];
		if (FB < 24 && (in_len >> FB) != 24'd0) begin
			len_sat = FadeMax;
		end else begin
			len_sat = FB'(in_len);
		end
		from_vol = lrsvf_pkg::PctTable[in_from[6:0]];
		to_vol = lrsvf_pkg::PctTable[in_to];
	end

	always_comb begin
		step_eff = SW'(step_q);
		if (step_eff < SW'(MinStep)) begin
			step_eff = SW'(MinStep);
		end
		diff_neg = target_q < start_q;
		abs_diff = diff_neg ? start_q - target_q : target_q - start_q;
		done_cnt = span_q - rem_q;
		cur_sel = ch_q ? cur_r_q : cur_l_q;
		nxt_sel = ch_q ? nxt_r_q : nxt_l_q;
		frame_diff = 17'(nxt_sel) - 17'(cur_sel);
		cur_shift = IW'(cur_sel) <<< F;
		hi_ext = SUMW'($signed(prod_q[HPW-1:0]));
		biased = psum_q + (psum_q[SUMW-1] ? RoundBias : '0);
		quot = RW'(biased >>> SH);
		if (quot > RW'(32767)) begin
			clamped = 16'sh7fff;
		end else if (quot < -RW'(32768)) begin
			clamped = 16'sh8000;
		end else begin
			clamped = quot[15:0];
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_FADE_MUL: begin
				mul_a = $signed(MA'(done_cnt));
				mul_b = $signed(MB'(abs_diff));
			end
			S_CH_MUL: begin
				mul_a = $signed(MA'(phase_q[F-1:0]));
				mul_b = MB'(frame_diff);
			end
			S_CH_LO: begin
				mul_a = $signed(MA'(vol_q));
				mul_b = $signed(MB'(interp_q[15:0]));
			end
			S_CH_HI: begin
				mul_a = MA'($signed(interp_q[IW-1:16]));
				mul_b = $signed(MB'(vol_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign div_start = (state_q == S_FADE_START);

	lrsvf_div #(
		.DW(FB),
		.QW(17),
		.NW(NW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(prod_q[NW-1:0]),
		.divisor(span_q),
		.busy(div_busy),
		.quotient(div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= lrsvf_pkg::StepReset;
			mono_q <= 1'b0;
			cur_l_q <= '0;
			cur_r_q <= '0;
			nxt_l_q <= '0;
			nxt_r_q <= '0;
			phase_q <= '0;
			prime_q <= '0;
			finished_q <= 1'b0;
			vol_q <= lrsvf_pkg::VolOne;
			target_q <= lrsvf_pkg::VolOne;
			start_q <= '0;
			rem_q <= '0;
			span_q <= '0;
			stop_fade_q <= 1'b0;
			last_q <= 1'b0;
			cnt_q <= '0;
			ch_q <= 1'b0;
			pend_valid_q <= 1'b0;
			m_valid_q <= 1'b0;
			m_last_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[2])
					lrsvf_pkg::REG_STEP_RATIO:  step_q <= pwdata[lrsvf_pkg::StepWidth-1:0];
					lrsvf_pkg::REG_MONO_SOURCE: mono_q <= pwdata[0];
					default:                    step_q <= step_q;
				endcase
			end
			if (m_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && !finished_q) begin
						case (s_axis_tuser)
							lrsvf_pkg::REQ_FRAME: begin
								last_q <= s_axis_tlast;
								cnt_q <= '0;
								if (prime_q == 2'd0) begin
									cur_l_q <= in_l;
									cur_r_q <= in_r;
									if (!s_axis_tlast) begin
										prime_q <= 2'd1;
									end else begin
										nxt_l_q <= in_l;
										nxt_r_q <= in_r;
										phase_q <= '0;
										prime_q <= 2'd2;
										state_q <= S_LOOP;
									end
								end else if (prime_q == 2'd1) begin
									nxt_l_q <= in_l;
									nxt_r_q <= in_r;
									phase_q <= '0;
									prime_q <= 2'd2;
									state_q <= S_LOOP;
								end else begin
									cur_l_q <= nxt_l_q;
									cur_r_q <= nxt_r_q;
									nxt_l_q <= in_l;
									nxt_r_q <= in_r;
									phase_q <= (phase_q >= PhaseOne) ? phase_q - PhaseOne : '0;
									state_q <= S_LOOP;
								end
							end
							lrsvf_pkg::REQ_VOLUME: begin
								target_q <= to_vol;
								span_q <= len_sat;
								rem_q <= len_sat;
								stop_fade_q <= 1'b0;
								start_q <= in_from[7] ? vol_q : from_vol;
								if (in_len == 24'd0) begin
									vol_q <= to_vol;
								end else if (!in_from[7]) begin
									vol_q <= from_vol;
								end
							end
							lrsvf_pkg::REQ_STOP: begin
								if (in_len == 24'd0) begin
									finished_q <= 1'b1;
								end else begin
									start_q <= vol_q;
									target_q <= '0;
									span_q <= len_sat;
									rem_q <= len_sat;
									stop_fade_q <= 1'b1;
								end
							end
							default: begin
								finished_q <= finished_q;
							end
						endcase
					end
				end
				S_LOOP: begin
					ch_q <= 1'b0;
					if (!finished_q && phase_q < PhaseOne && cnt_q < CW'(MAX_OUTPUTS)) begin
						if (rem_q != '0 && span_q != '0) begin
							state_q <= S_FADE_MUL;
						end else begin
							state_q <= S_CH_MUL;
						end
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_FADE_MUL: state_q <= S_FADE_START;
				S_FADE_START: state_q <= S_FADE_DIV;
				S_FADE_DIV: begin
					if (!div_busy) begin
						state_q <= S_FADE_UPD;
					end
				end
				S_FADE_UPD: begin
					rem_q <= rem_q - 1'b1;
					if (rem_q == FB'(1)) begin
						vol_q <= target_q;
						if (stop_fade_q) begin
							finished_q <= 1'b1;
							state_q <= S_LOOP;
						end else begin
							state_q <= S_CH_MUL;
						end
					end else begin
						vol_q <= diff_neg ? start_q - div_q : start_q + div_q;
						state_q <= S_CH_MUL;
					end
				end
				S_CH_MUL: state_q <= S_CH_INT;
				S_CH_INT: state_q <= S_CH_LO;
				S_CH_LO: state_q <= S_CH_HI;
				S_CH_HI: state_q <= S_CH_SUM;
				S_CH_SUM: state_q <= S_CH_CLAMP;
				S_CH_CLAMP: begin
					if (!ch_q) begin
						ch_q <= 1'b1;
						state_q <= S_CH_MUL;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!pend_valid_q || out_free) begin
						if (pend_valid_q) begin
							m_last_q <= 1'b0;
						end
						pend_valid_q <= 1'b1;
						cnt_q <= cnt_q + 1'b1;
						phase_q <= phase_q + PHW'(step_eff);
						state_q <= S_LOOP;
					end
				end
				S_FINISH: begin
					if (!pend_valid_q || out_free) begin
						if (pend_valid_q) begin
							m_last_q <= 1'b1;
						end
						pend_valid_q <= 1'b0;
						if (last_q) begin
							finished_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CH_INT) begin
			interp_q <= cur_shift + IW'(prod_q);
		end
		if (state_q == S_CH_HI) begin
			plo_q <= prod_q[32:0];
		end
		if (state_q == S_CH_SUM) begin
			psum_q <= (hi_ext <<< 16) + $signed(SUMW'(plo_q));
		end
		if (state_q == S_CH_CLAMP) begin
			if (ch_q) begin
				res_r_q <= clamped;
			end else begin
				res_l_q <= clamped;
			end
		end
		if (state_q == S_EMIT && (!pend_valid_q || out_free)) begin
			pend_l_q <= res_l_q;
			pend_r_q <= res_r_q;
		end
		if (m_load) begin
			m_l_q <= pend_l_q;
			m_r_q <= pend_r_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tlast = m_last_q;
	assign m_axis_tdata = {m_r_q, m_l_q};

	`LRSVF_ASSERT(a_idle_no_pending, !(s_axis_tready && pend_valid_q), "result pending while idle")
	`LRSVF_ASSERT(a_count_bound, cnt_q <= CW'(MAX_OUTPUTS), "output count past limit")
	`LRSVF_ASSERT(a_fade_order, rem_q <= span_q, "fade remaining exceeds span")
	`LRSVF_ASSERT(a_div_owner, !div_busy || state_q == S_FADE_DIV, "divider busy outside wait")
	`LRSVF_ASSERT_NEXT(a_start_div, state_q == S_FADE_START, div_busy, "divider did not start")
endmodule
`default_nettype wire

>>> verif/linear_resampler_with_volume_fade_unit_tb.sv
// Self-checking testbench for the linear resampler with volume slide.
`timescale 1ns / 1ps
module linear_resampler_with_volume_fade_unit_tb;
	localparam logic [1:0] ReqReserved = 2'd3;
	localparam longint PhaseOne = 64'd65536;
	localparam longint MinStep = 64'd1024;
	localparam int MaxOut = 64;
	localparam int StallLimit = 20000;
	localparam int HoldCycles = 2000;
	localparam logic [2:0] AddrStep = {lrsvf_pkg::REG_STEP_RATIO, 2'b00};
	localparam logic [2:0] AddrMono = {lrsvf_pkg::REG_MONO_SOURCE, 2'b00};

	typedef struct {
		logic [15:0] left;
		logic [15:0] right;
		logic        last;
	} frame_out_t;

	typedef struct {
		lrsvf_pkg::req_t req;
		logic [15:0] left;
		logic [15:0] right;
		logic        last;
		logic [7:0]  from_pct;
		logic [6:0]  to_pct;
		logic [23:0] fade_len;
		int          nres;
		frame_out_t  res [MaxOut];
	} request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic m_axis_tlast;

	request_t pending_requests[$];
	frame_out_t expected_frames[$];
	request_t in_flight;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int frames_seen = 0;
	int idle_cycles = 0;
	int mismatches = 0;

	// Channel state mirrored for prediction.
	int cur_smp [2];
	int nxt_smp [2];
	longint phase;
	int prime;
	bit done_snd;
	longint vol_now, vol_tgt, vol_from;
	longint fade_rem, fade_tot;
	bit fade_stops;
	longint step_cfg;
	bit mono_cfg;

	linear_resampler_with_volume_fade_unit dut (.*);

	always #2 clk = ~clk;

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic longint pct_to_q16(longint p);
		if (p > 100) p = 100;
		return (p * 65536 + 50) / 100;
	endfunction

	function automatic logic [15:0] scaled(int c, int n);
		longint interp, prod, q;
		interp = longint'(c) * PhaseOne + longint'(n - c) * phase;
		prod = interp * vol_now;
		q = (prod < 0 ? -prod : prod) >>> 32;
		if (prod < 0) q = -q;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[15:0];
	endfunction

	function automatic void render_outputs(ref request_t it);
		longint stp, diff, mag;
		stp = step_cfg < MinStep ? MinStep : step_cfg;
		while (!done_snd && phase < PhaseOne && it.nres < MaxOut) begin
			if (fade_rem > 0 && fade_tot > 0) begin
				diff = vol_tgt - vol_from;
				mag = (diff < 0 ? -diff : diff) * (fade_tot - fade_rem) / fade_tot;
				vol_now = diff < 0 ? vol_from - mag : vol_from + mag;
				fade_rem--;
				if (fade_rem == 0) begin
					vol_now = vol_tgt;
					if (fade_stops) begin
						done_snd = 1'b1;
						break;
					end
				end
			end
			it.res[it.nres].left = scaled(cur_smp[0], nxt_smp[0]);
			it.res[it.nres].right = scaled(cur_smp[1], nxt_smp[1]);
			it.res[it.nres].last = 1'b0;
			it.nres++;
			phase += stp;
		end
		if (it.nres > 0) it.res[it.nres - 1].last = 1'b1;
	endfunction

	function automatic void begin_slide(longint tgt, longint len, bit stops);
		vol_from = vol_now;
		vol_tgt = tgt;
		fade_tot = len;
		fade_rem = len;
		fade_stops = stops;
	endfunction

	function automatic void predict_request(ref request_t it);
		int l, r;
		longint tgt;
		it.nres = 0;
		if (done_snd) return;
		case (it.req)
			lrsvf_pkg::REQ_FRAME: begin
				l = int'($signed(it.left));
				r = mono_cfg ? l : int'($signed(it.right));
				if (prime == 0) begin
					cur_smp[0] = l;
					cur_smp[1] = r;
					if (!it.last) begin
						prime = 1;
						return;
					end
					nxt_smp[0] = l;
					nxt_smp[1] = r;
					phase = 0;
					prime = 2;
				end else if (prime == 1) begin
					nxt_smp[0] = l;
					nxt_smp[1] = r;
					phase = 0;
					prime = 2;
				end else begin
					cur_smp = nxt_smp;
					nxt_smp[0] = l;
					nxt_smp[1] = r;
					phase = phase >= PhaseOne ? phase - PhaseOne : 0;
				end
				render_outputs(it);
				if (it.last) done_snd = 1'b1;
			end
			lrsvf_pkg::REQ_VOLUME: begin
				tgt = pct_to_q16(longint'(it.to_pct));
				if (!it.from_pct[7]) vol_now = pct_to_q16(longint'(it.from_pct));
				begin_slide(tgt, longint'(it.fade_len), 1'b0);
				if (it.fade_len == 0) vol_now = tgt;
			end
			lrsvf_pkg::REQ_STOP: begin
				if (it.fade_len == 0) done_snd = 1'b1;
				else begin_slide(0, longint'(it.fade_len), 1'b1);
			end
			default: ;
		endcase
	endfunction

	function automatic request_t make_request(lrsvf_pkg::req_t req, logic [15:0] l,
			logic [15:0] r, logic last, logic [7:0] from_p, logic [6:0] to_p,
			logic [23:0] len);
		request_t it;
		it.req = req;
		it.left = l;
		it.right = r;
		it.last = last;
		it.from_pct = from_p;
		it.to_pct = to_p;
		it.fade_len = len;
		it.nres = 0;
		return it;
	endfunction

	task automatic queue_request(request_t it);
		predict_request(it);
		pending_requests.push_back(it);
	endtask

	task automatic queue_frame(logic last);
		queue_request(make_request(lrsvf_pkg::REQ_FRAME, 16'($urandom), 16'($urandom), last,
			8'($urandom), 7'($urandom), 24'($urandom)));
	endtask

	// Keeps a running stop fade from ending the sound before the final phase.
	task automatic guard_stop_fade();
		if (fade_stops && fade_rem > 0 && fade_rem <= MaxOut)
			queue_request(make_request(lrsvf_pkg::REQ_VOLUME, 16'($urandom), 16'($urandom),
				1'b0, 8'($urandom), 7'($urandom_range(0, 127)), 24'($urandom_range(0, 30))));
	endtask

	task automatic queue_random();
		int kind;
		logic [23:0] len;
		kind = $urandom_range(0, 99);
		len = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 40));
		if (kind < 68) begin
			guard_stop_fade();
			queue_frame(1'b0);
		end else if (kind < 86) begin
			queue_request(make_request(lrsvf_pkg::REQ_VOLUME, 16'($urandom), 16'($urandom),
				1'($urandom), 8'($urandom), 7'($urandom), len));
		end else if (kind < 94) begin
			queue_request(make_request(lrsvf_pkg::REQ_STOP, 16'($urandom), 16'($urandom), 1'b0,
				8'($urandom), 7'($urandom), 24'($urandom_range(1, 300))));
		end else begin
			queue_request(make_request(lrsvf_pkg::req_t'(ReqReserved), 16'($urandom),
				16'($urandom), 1'($urandom), 8'($urandom), 7'($urandom), 24'($urandom)));
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_requests.size() > 0 || s_axis_tvalid || expected_frames.size() > 0)
			@(negedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(longint stp, bit mono);
		apb_write(AddrStep, 32'(stp));
		apb_write(AddrMono, 32'(mono));
		step_cfg = stp & 64'h7FFFF;
		mono_cfg = mono;
	endtask

	// Sender: one transfer per handshake, random gaps between items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid)
				for (int i = 0; i < in_flight.nres; i++)
					expected_frames.push_back(in_flight.res[i]);
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				in_flight = pending_requests.pop_front();
				s_axis_tdata <= {1'b0, in_flight.fade_len, in_flight.to_pct,
					in_flight.from_pct, in_flight.right, in_flight.left};
				s_axis_tuser <= in_flight.req;
				s_axis_tlast <= in_flight.last;
				s_axis_tvalid <= 1'b1;
				send_gap = draw_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off so the block backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && frames_seen >= 150) begin
			hold_done = 1'b1;
			hold_left = HoldCycles;
			m_axis_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			recv_gap = draw_gap();
		end
	end

	always @(posedge clk) begin
		frame_out_t want;
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= StallLimit) begin
				$display("== FAIL ==");
				$finish;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				frames_seen++;
				if (expected_frames.size() == 0) begin
					$error("unexpected output transfer %h", m_axis_tdata);
					mismatches++;
				end else begin
					want = expected_frames.pop_front();
					if (m_axis_tdata[15:0] !== want.left) begin
						$error("left_out: expected %h, actual %h", want.left, m_axis_tdata[15:0]);
						mismatches++;
					end
					if (m_axis_tdata[31:16] !== want.right) begin
						$error("right_out: expected %h, actual %h", want.right,
							m_axis_tdata[31:16]);
						mismatches++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last_of_run: expected %b, actual %b", want.last, m_axis_tlast);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		longint steps [6] = '{65536, 0, 64'h7FFFF, 0, 262144, 1024};
		bit monos [6] = '{0, 1, 0, 0, 1, 0};
		int ending;
		cur_smp = '{0, 0};
		nxt_smp = '{0, 0};
		phase = 0;
		prime = 0;
		done_snd = 1'b0;
		vol_now = 65536;
		vol_tgt = 65536;
		vol_from = 0;
		fade_rem = 0;
		fade_tot = 0;
		fade_stops = 1'b0;
		step_cfg = 65536;
		mono_cfg = 1'b0;
		steps[3] = $urandom_range(1024, 262144);
		monos[3] = 1'($urandom);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 6; ph++) begin
			set_config(steps[ph], monos[ph]);
			if (ph == 0) begin
				queue_request(make_request(lrsvf_pkg::REQ_FRAME, 16'h7FFF, 16'h8000, 1'b0,
					0, 0, 0));
				queue_request(make_request(lrsvf_pkg::REQ_FRAME, 16'h8000, 16'h7FFF, 1'b0,
					0, 0, 0));
				queue_request(make_request(lrsvf_pkg::REQ_FRAME, 16'h7FFF, 16'h7FFF, 1'b0,
					0, 0, 0));
				queue_request(make_request(lrsvf_pkg::REQ_VOLUME, 0, 0, 1'b0,
					8'd127, 7'd127, 0));
				queue_request(make_request(lrsvf_pkg::REQ_FRAME, 16'h8000, 16'h8000, 1'b0,
					0, 0, 0));
				queue_request(make_request(lrsvf_pkg::REQ_VOLUME, 0, 0, 1'b0,
					8'hFF, 7'd0, 24'd5));
				queue_request(make_request(lrsvf_pkg::REQ_FRAME, 16'h7FFF, 16'h0000, 1'b0,
					0, 0, 0));
				queue_request(make_request(lrsvf_pkg::REQ_FRAME, 16'h1234, 16'hFFFF, 1'b0,
					0, 0, 0));
				queue_request(make_request(lrsvf_pkg::REQ_VOLUME, 0, 0, 1'b0,
					8'd0, 7'd100, 24'd3));
				queue_request(make_request(lrsvf_pkg::REQ_FRAME, 16'h8000, 16'h7FFF, 1'b0,
					0, 0, 0));
				queue_request(make_request(lrsvf_pkg::REQ_VOLUME, 0, 0, 1'b0,
					8'd100, 7'd100, 24'hFFFFFF));
				queue_request(make_request(lrsvf_pkg::REQ_FRAME, 16'h0001, 16'hFFFF, 1'b0,
					0, 0, 0));
				queue_request(make_request(lrsvf_pkg::REQ_STOP, 0, 0, 1'b0, 0, 0, 24'd20));
				queue_request(make_request(lrsvf_pkg::REQ_FRAME, 16'h4000, 16'hC000, 1'b0,
					0, 0, 0));
				queue_request(make_request(lrsvf_pkg::req_t'(ReqReserved), 16'hFFFF, 16'hFFFF,
					1'b1, 8'hFF, 7'h7F, 24'hFFFFFF));
				queue_request(make_request(lrsvf_pkg::REQ_VOLUME, 0, 0, 1'b1,
					8'd50, 7'd100, 0));
				queue_request(make_request(lrsvf_pkg::REQ_FRAME, 16'h0000, 16'h0000, 1'b0,
					0, 0, 0));
			end
			for (int i = 0; i < 73; i++) begin
				if (ph == 2 && i == 30) wait_idle();
				queue_random();
			end
			wait_idle();
		end
		ending = $urandom_range(0, 2);
		if (ending == 0) begin
			guard_stop_fade();
			queue_frame(1'b1);
		end else if (ending == 1) begin
			queue_request(make_request(lrsvf_pkg::REQ_STOP, 0, 0, 1'b0, 0, 0, 0));
		end else begin
			queue_request(make_request(lrsvf_pkg::REQ_STOP, 0, 0, 1'b0, 0, 0, 24'd5));
			for (int i = 0; i < 10 && !done_snd; i++) queue_frame(1'b0);
		end
		for (int i = 0; i < 6; i++) begin
			queue_request(make_request(lrsvf_pkg::req_t'(2'($urandom)), 16'($urandom),
				16'($urandom), 1'($urandom), 8'($urandom), 7'($urandom),
				24'($urandom_range(0, 9))));
		end
		wait_idle();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
